[hdl/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/ifst_pkg.sv]
package ifst_pkg;
    localparam int FLOW_SLOTS_DEF = 256;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [3:0] IPVERSION = 4'd4;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [17:0] POS_MAX = 18'h3FFFF;
    localparam logic [31:0] PKT_MAX = 32'hFFFFFFFF;
    localparam logic [47:0] BYTES_MAX = 48'hFFFFFFFFFFFF;

    localparam logic [1:0] KIND_COUNTED = 2'd0;
    localparam logic [1:0] KIND_IGNORED = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    // one job handed from the frame parser to the table engine
    typedef struct packed {
        logic        is_read;
        logic        ok;
        logic [7:0]  read_index;
        logic [63:0] key;
        logic [31:0] ports;
        logic [17:0] wire_length;
    } job_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        entry_valid;
        logic [7:0]  flow_index;
        logic [63:0] key;
        logic [31:0] ports;
        logic [31:0] packets;
        logic [47:0] bytes;
    } result_t;
endpackage

[hdl/ifst_parser.sv]
module ifst_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            op,
    input  logic [7:0]      packet_byte,
    input  logic            last_byte,
    input  logic [17:0]     wire_length,
    input  logic [7:0]      read_index,
    output logic            job_valid,
    input  logic            job_stall,
    output ifst_pkg::job_t  job
);
    import ifst_pkg::*;

    logic [17:0] pos_reg, pos_next;
    logic [63:0] addr_reg, addr_next;
    logic [31:0] ports_reg, ports_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic        qual_reg, qual_next;
    logic        jv_reg, jv_next;
    job_t        job_reg, job_next;
    logic        take, emit;
    logic [3:0]  ihl;
    logic [18:0] port_off, cnt;

    assign in_stall = jv_reg && job_stall;
    assign take = in_valid && !in_stall;
    assign job_valid = jv_reg;
    assign job = job_reg;

    always_comb
    begin
        pos_next = pos_reg;
        addr_next = addr_reg;
        ports_next = ports_reg;
        ihl_next = ihl_reg;
        qual_next = qual_reg;
        job_next = job_reg;
        emit = 1'b0;
        ihl = (pos_reg == 18'd14) ? packet_byte[3:0] : ihl_reg;
        port_off = 19'd14 + {13'd0, ihl, 2'b00};
        cnt = {1'b0, pos_reg} + 19'd1;
        if (take)
        begin
            if (op)
            begin
                emit = 1'b1;
                job_next = '0;
                job_next.is_read = 1'b1;
                job_next.read_index = read_index;
            end
            else
            begin
                if (pos_reg == 18'd12 && packet_byte != ETH_TYPE_IPV4[15:8])
                    qual_next = 1'b0;
                if (pos_reg == 18'd13 && packet_byte != ETH_TYPE_IPV4[7:0])
                    qual_next = 1'b0;
                if (pos_reg == 18'd14)
                begin
                    if (packet_byte[7:4] != IPVERSION)
                        qual_next = 1'b0;
                    ihl_next = ihl;
                end
                if (pos_reg == 18'd23 && packet_byte != PROTO_TCP
                    && packet_byte != PROTO_UDP)
                    qual_next = 1'b0;
                if (pos_reg >= 18'd26 && pos_reg <= 18'd33)
                    addr_next = {addr_reg[55:0], packet_byte};
                if ({1'b0, pos_reg} >= port_off && {1'b0, pos_reg} < port_off + 19'd4)
                    ports_next = {ports_reg[23:0], packet_byte};
                if (last_byte)
                begin
                    emit = 1'b1;
                    job_next.is_read = 1'b0;
                    job_next.read_index = '0;
                    job_next.ok = qual_next && cnt >= 19'd34 && cnt >= port_off + 19'd4;
                    job_next.key = addr_next;
                    job_next.ports = ports_next;
                    job_next.wire_length = wire_length;
                    pos_next = '0;
                    addr_next = '0;
                    ports_next = '0;
                    ihl_next = '0;
                    qual_next = 1'b1;
                end
                else if (pos_reg < POS_MAX)
                    pos_next = pos_reg + 18'd1;
            end
        end
        jv_next = emit ? 1'b1 : (job_stall ? jv_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            addr_reg <= '0;
            ports_reg <= '0;
            ihl_reg <= '0;
            qual_reg <= 1'b1;
            jv_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            addr_reg <= addr_next;
            ports_reg <= ports_next;
            ihl_reg <= ihl_next;
            qual_reg <= qual_next;
            jv_reg <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end
endmodule

[hdl/ifst_fifo.sv]
module ifst_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_stall,
    input  ifst_pkg::job_t  wr_data,
    output logic            rd_valid,
    input  logic            rd_take,
    output ifst_pkg::job_t  rd_data
);
    import ifst_pkg::*;

    job_t       mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    assign wr_stall = (cnt_reg == 3'd4);
    assign push = wr_valid && !wr_stall;
    assign rd_valid = (cnt_reg != 3'd0);
    assign pop = rd_valid && rd_take;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

[hdl/ifst_engine.sv]
`include "assert_macros.svh"
module ifst_engine
#(
    parameter int FLOW_SLOTS = ifst_pkg::FLOW_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_take,
    input  ifst_pkg::job_t    job,
    output logic              res_valid,
    input  logic              res_stall,
    output ifst_pkg::result_t res
);
    import ifst_pkg::*;

    localparam int IW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;

    typedef enum logic [5:0]
    {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_SCAN = 6'b000100,
        S_CHK  = 6'b001000,
        S_UPD  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [FLOW_SLOTS-1:0] used_reg;
    logic [63:0] key_mem [FLOW_SLOTS];
    logic [31:0] port_mem [FLOW_SLOTS];
    logic [31:0] pkt_mem [FLOW_SLOTS];
    logic [47:0] byt_mem [FLOW_SLOTS];
    logic [63:0] rkey_reg;
    logic [31:0] rport_reg, rpkt_reg;
    logic [47:0] rbyt_reg;
    logic [IW:0] scan_reg, scan_next;
    logic [IW-1:0] addr, hit_reg, hit_next, free_reg, free_next;
    logic found_reg, found_next, hfree_reg, hfree_next;
    logic rd_used_reg;
    job_t job_reg;
    logic rv_reg, rv_next;
    result_t res_reg, res_next;
    logic wr_en;
    logic [31:0] new_pkt;
    logic [47:0] new_byt;
    logic [48:0] bsum;

    assign res_valid = rv_reg;
    assign res = res_reg;
    // a new job starts only once the result register is free
    assign job_take = (state_reg == S_IDLE) && job_valid && !(rv_reg && res_stall);

    always_comb
    begin
        addr = scan_reg[IW-1:0];
        if (state_reg == S_IDLE)
            addr = IW'(job.read_index);
        else if (state_reg == S_UPD || state_reg == S_CHK)
            addr = hit_reg;
    end

    always_ff @(posedge clk)
    begin
        rkey_reg <= key_mem[addr];
        rport_reg <= port_mem[addr];
        rpkt_reg <= pkt_mem[addr];
        rbyt_reg <= byt_mem[addr];
        rd_used_reg <= used_reg[addr];
        if (job_take)
            job_reg <= job;
        if (wr_en)
        begin
            key_mem[hit_reg] <= job_reg.key;
            port_mem[hit_reg] <= job_reg.ports;
            pkt_mem[hit_reg] <= new_pkt;
            byt_mem[hit_reg] <= new_byt;
        end
        res_reg <= res_next;
        scan_reg <= scan_next;
        hit_reg <= hit_next;
        free_reg <= free_next;
        found_reg <= found_next;
        hfree_reg <= hfree_next;
    end

    always_comb
    begin
        state_next = state_reg;
        scan_next = scan_reg;
        hit_next = hit_reg;
        free_next = free_reg;
        found_next = found_reg;
        hfree_next = hfree_reg;
        res_next = res_reg;
        rv_next = rv_reg && res_stall;
        wr_en = 1'b0;
        bsum = {1'b0, rbyt_reg} + {31'd0, job_reg.wire_length};
        if (found_reg)
        begin
            new_pkt = (rpkt_reg == PKT_MAX) ? rpkt_reg : rpkt_reg + 32'd1;
            new_byt = bsum[48] ? BYTES_MAX : bsum[47:0];
        end
        else
        begin
            new_pkt = 32'd1;
            new_byt = {30'd0, job_reg.wire_length};
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_take)
                begin
                    found_next = 1'b0;
                    hfree_next = 1'b0;
                    if (job.is_read)
                    begin
                        scan_next = '0;
                        if ({24'd0, job.read_index} < 32'(FLOW_SLOTS))
                            scan_next = (IW+1)'(job.read_index);
                        state_next = S_READ;
                    end
                    else if (!job.ok)
                    begin
                        res_next = '0;
                        res_next.kind = KIND_IGNORED;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        scan_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_READ:
            begin
                res_next = '0;
                res_next.kind = KIND_READ;
                res_next.flow_index = job_reg.read_index;
                if ({24'd0, job_reg.read_index} < 32'(FLOW_SLOTS) && rd_used_reg)
                begin
                    res_next.entry_valid = 1'b1;
                    res_next.key = rkey_reg;
                    res_next.ports = rport_reg;
                    res_next.packets = rpkt_reg;
                    res_next.bytes = rbyt_reg;
                end
                state_next = S_OUT;
            end
            S_SCAN:
            begin
                // issue one address per cycle; its data is checked in the next cycle
                if (scan_reg != '0 && !found_reg)
                begin
                    if (rd_used_reg)
                    begin
                        if (rkey_reg == job_reg.key && rport_reg == job_reg.ports)
                        begin
                            found_next = 1'b1;
                            hit_next = IW'(scan_reg - 1'b1);
                        end
                    end
                    else if (!hfree_reg)
                    begin
                        hfree_next = 1'b1;
                        free_next = IW'(scan_reg - 1'b1);
                    end
                end
                if (found_next || scan_reg == (IW+1)'(FLOW_SLOTS))
                    state_next = S_CHK;
                else
                    scan_next = scan_reg + 1'b1;
            end
            S_CHK:
            begin
                if (found_reg)
                    state_next = S_UPD;
                else if (hfree_reg)
                begin
                    hit_next = free_reg;
                    state_next = S_UPD;
                end
                else
                begin
                    res_next = '0;
                    res_next.kind = KIND_FULL;
                    res_next.key = job_reg.key;
                    res_next.ports = job_reg.ports;
                    res_next.packets = 32'd1;
                    res_next.bytes = {30'd0, job_reg.wire_length};
                    state_next = S_OUT;
                end
            end
            S_UPD:
            begin
                wr_en = 1'b1;
                res_next.kind = KIND_COUNTED;
                res_next.entry_valid = 1'b1;
                res_next.flow_index = 8'(hit_reg);
                res_next.key = job_reg.key;
                res_next.ports = job_reg.ports;
                res_next.packets = new_pkt;
                res_next.bytes = new_byt;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rv_reg || !res_stall)
                begin
                    rv_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    res_next = res_reg;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg <= 1'b0;
            used_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg <= rv_next;
            if (wr_en)
                used_reg[hit_reg] <= 1'b1;
        end
    end

    `ASSERT_NEXT(a_take_leaves_idle, job_take, state_reg != S_IDLE)
    `ASSERT_IMPL(a_upd_valid, state_reg == S_UPD, found_reg || hfree_reg)
    `ASSERT_NEXT(a_out_held, rv_reg && res_stall, rv_reg && $stable(res_reg))
endmodule

[hdl/ipv4_flow_statistics_table.sv]
// Counted frames use a linear table search, one slot per cycle; reads and ignored
// frames skip it. The engine finishes one job before it takes the next; frame
// bytes go in one per cycle while the 4-deep job queue has room, and a stalled
// result holds the engine.
// Reset: asynchronous active low, clears the parser state, the job queue, the engine
// state and result valid flag, and all slot valid bits.
module ipv4_flow_statistics_table
#(
    parameter int FLOW_SLOTS = ifst_pkg::FLOW_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  packet_byte,
    input  logic        last_byte,
    input  logic [17:0] wire_length,
    input  logic [7:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic        entry_valid,
    output logic [7:0]  flow_index,
    output logic [31:0] src_ip,
    output logic [31:0] dst_ip,
    output logic [15:0] sport,
    output logic [15:0] dport,
    output logic [31:0] packet_total,
    output logic [47:0] byte_total
);
    import ifst_pkg::*;

    logic    pj_valid, pj_stall, qj_valid, qj_take;
    job_t    pj, qj;
    result_t r;

    ifst_parser u_parser
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .packet_byte(packet_byte), .last_byte(last_byte),
        .wire_length(wire_length), .read_index(read_index),
        .job_valid(pj_valid), .job_stall(pj_stall), .job(pj)
    );

    ifst_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n), .wr_valid(pj_valid), .wr_stall(pj_stall),
        .wr_data(pj), .rd_valid(qj_valid), .rd_take(qj_take), .rd_data(qj)
    );

    ifst_engine #(.FLOW_SLOTS(FLOW_SLOTS)) u_engine
    (
        .clk(clk), .rst_n(rst_n), .job_valid(qj_valid), .job_take(qj_take),
        .job(qj), .res_valid(out_valid), .res_stall(out_stall), .res(r)
    );

    assign kind = r.kind;
    assign entry_valid = r.entry_valid;
    assign flow_index = r.flow_index;
    assign src_ip = r.key[63:32];
    assign dst_ip = r.key[31:0];
    assign sport = r.ports[31:16];
    assign dport = r.ports[15:0];
    assign packet_total = r.packets;
    assign byte_total = r.bytes;
endmodule
